/* sv/assert_macros.svh */
// Assertion macros used by the datapath RTL file of the scheduler core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// cons must hold at every edge where ante holds
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

/* sv/ffexrr_pkg.sv */
// Package of the five-queue exponential round robin scheduler core.
// Field widths, result codes, controller/datapath structs and queue selection.
// No dependencies.
`timescale 1ns / 1ps

package ffexrr_pkg;

    localparam int QUEUE_DEPTH_DEF = 4096;
    localparam int NUM_QUEUES_DEF  = 5;
    localparam int MAX_SLOTS_DEF   = 32;

    localparam int TASK_W   = 22;
    localparam int WEIGHT_W = 14;
    localparam int SLOTS_W  = 6;
    localparam int KIND_W   = 3;
    localparam int QIDX_W   = 3;
    localparam int THERM_W  = 2;

    localparam int TASK_LSB   = 0;
    localparam int WEIGHT_LSB = TASK_LSB + TASK_W;
    localparam int REENQ_BIT  = WEIGHT_LSB + WEIGHT_W;
    localparam int GPEND_BIT  = REENQ_BIT + 1;
    localparam int SLOTS_LSB  = GPEND_BIT + 1;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 32;
    localparam int M_PAD_W    = M_TDATA_W - TASK_W - QIDX_W;

    localparam logic [KIND_W-1:0] KIND_QUEUED      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TO_GLOBAL   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DISPATCHED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MOVE_GLOBAL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOTHING     = 3'd4;

    localparam logic [THERM_W-1:0] THERM_COOL     = 2'd0;
    localparam logic [THERM_W-1:0] THERM_WARM     = 2'd1;
    localparam logic [THERM_W-1:0] THERM_HOT      = 2'd2;
    localparam logic [THERM_W-1:0] THERM_CRITICAL = 2'd3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_LVL0 = 14'd25;
    localparam logic [WEIGHT_W-1:0] WEIGHT_LVL1 = 14'd50;
    localparam logic [WEIGHT_W-1:0] WEIGHT_LVL2 = 14'd200;
    localparam logic [WEIGHT_W-1:0] WEIGHT_LVL3 = 14'd400;

    typedef struct packed {
        logic load;
        logic scan_clear;
        logic enqueue;
        logic advance;
        logic skip;
        logic pop_read;
        logic pop_take;
        logic flush_mid;
        logic emit_global;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic command;
        logic gpend;
        logic slots_zero;
        logic slots_one;
        logic queue_empty;
        logic remain_one;
        logic scan_last;
        logic held_valid;
        logic out_free;
    } ctrl_stat_t;

    // queue by weight, then thermal bias; clamp to the queue count is left to the caller
    function automatic logic [QIDX_W-1:0] pick_queue(input logic [WEIGHT_W-1:0] weight,
                                                     input logic [THERM_W-1:0] thermal);
        logic [QIDX_W-1:0] idx;
        if (weight <= WEIGHT_LVL0)
            idx = 3'd0;
        else if (weight <= WEIGHT_LVL1)
            idx = 3'd1;
        else if (weight < WEIGHT_LVL2)
            idx = 3'd2;
        else if (weight < WEIGHT_LVL3)
            idx = 3'd3;
        else
            idx = 3'd4;
        case (thermal)
            THERM_WARM:
            begin
                if (idx != 3'd0)
                    idx = idx - 3'd1;
            end
            THERM_HOT:
            begin
                if (idx > 3'd2)
                    idx = 3'd2;
            end
            THERM_CRITICAL:
            begin
                if (idx > 3'd1)
                    idx = 3'd1;
            end
            default:
            begin
            end
        endcase
        return idx;
    endfunction

endpackage

/* sv/ffexrr_dp.sv */
// Datapath of the scheduler core: input and thermal registers, queue store,
// queue pointers, round robin cursor, held pop and output register.
// Depends on ffexrr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffexrr_dp #(
    parameter int QUEUE_DEPTH = ffexrr_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_QUEUES  = ffexrr_pkg::NUM_QUEUES_DEF,
    parameter int MAX_SLOTS   = ffexrr_pkg::MAX_SLOTS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wen,
    input  logic [ffexrr_pkg::THERM_W-1:0]         cfg_wdata,
    input  logic [ffexrr_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                   s_tuser,
    input  ffexrr_pkg::ctrl_cmd_t                  cmd,
    output ffexrr_pkg::ctrl_stat_t                 stat,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [ffexrr_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [ffexrr_pkg::KIND_W-1:0]          m_tuser,
    output logic                                   m_tlast
);

    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int FW        = $clog2(QUEUE_DEPTH + 1);
    localparam int TSW       = PW + 1;
    localparam int QW        = $clog2(NUM_QUEUES);
    localparam int RW        = NUM_QUEUES;
    localparam int CW        = $clog2(MAX_SLOTS + 1);
    localparam int AW        = QW + PW;
    localparam int MEM_DEPTH = NUM_QUEUES << PW;
    localparam int TW        = ffexrr_pkg::TASK_W;
    localparam int KW        = ffexrr_pkg::KIND_W;
    localparam int XW        = ffexrr_pkg::QIDX_W;

    logic [ffexrr_pkg::THERM_W-1:0]  thermal_reg;
    logic                            command_reg;
    logic [TW-1:0]                   task_reg;
    logic [ffexrr_pkg::WEIGHT_W-1:0] weight_reg;
    logic                            reenq_reg;
    logic                            gpend_reg;
    logic [CW-1:0]                   slots_reg, slots_next;
    logic [PW-1:0]                   head_reg [NUM_QUEUES];
    logic [PW-1:0]                   head_next [NUM_QUEUES];
    logic [FW-1:0]                   fill_reg [NUM_QUEUES];
    logic [FW-1:0]                   fill_next [NUM_QUEUES];
    logic [QW-1:0]                   cursor_reg, cursor_next;
    logic [RW-1:0]                   remain_reg, remain_next;
    logic [QW-1:0]                   scan_reg, scan_next;
    logic                            held_valid_reg, held_valid_next;
    logic [TW-1:0]                   held_task_reg;
    logic [QW-1:0]                   held_q_reg;
    logic [TW-1:0]                   rdata_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [KW-1:0]                   out_kind_reg, out_kind_next;
    logic [TW-1:0]                   out_task_reg, out_task_next;
    logic [XW-1:0]                   out_q_reg, out_q_next;
    logic                            out_last_reg, out_last_next;

    logic [TW-1:0] mem [MEM_DEPTH];

    logic [XW-1:0]                  pick;
    logic [QW-1:0]                  enq_q;
    logic [FW-1:0]                  enq_fill;
    logic                           enq_ok;
    logic [TSW-1:0]                 tail_sum;
    logic [PW-1:0]                  tail;
    logic                           mem_we;
    logic [FW-1:0]                  cur_fill;
    logic [PW-1:0]                  cur_head;
    logic [PW-1:0]                  head_inc;
    logic [QW-1:0]                  cursor_adv;
    logic [ffexrr_pkg::SLOTS_W-1:0] in_slots;
    logic [CW-1:0]                  slots_sat;
    logic                           out_free;
    logic                           out_load;

    assign in_slots  = s_tdata[ffexrr_pkg::SLOTS_LSB +: ffexrr_pkg::SLOTS_W];
    assign slots_sat = (in_slots > ffexrr_pkg::SLOTS_W'(MAX_SLOTS)) ? CW'(MAX_SLOTS)
                                                                    : CW'(in_slots);

    assign pick     = ffexrr_pkg::pick_queue(weight_reg, thermal_reg);
    assign enq_q    = (pick > XW'(NUM_QUEUES - 1)) ? QW'(NUM_QUEUES - 1) : QW'(pick);
    assign enq_fill = fill_reg[enq_q];
    assign enq_ok   = !reenq_reg && (enq_fill < FW'(QUEUE_DEPTH));
    assign tail_sum = TSW'(head_reg[enq_q]) + TSW'(enq_fill);
    assign tail     = (tail_sum >= TSW'(QUEUE_DEPTH)) ? PW'(tail_sum - TSW'(QUEUE_DEPTH))
                                                      : PW'(tail_sum);
    assign mem_we   = cmd.enqueue && enq_ok;

    assign cur_fill   = fill_reg[cursor_reg];
    assign cur_head   = head_reg[cursor_reg];
    assign head_inc   = (cur_head == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + PW'(1);
    assign cursor_adv = (cursor_reg == QW'(NUM_QUEUES - 1)) ? '0 : cursor_reg + QW'(1);

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = cmd.enqueue || (cmd.pop_take && held_valid_reg) || cmd.flush_mid
                      || cmd.emit_global || cmd.finish;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[{enq_q, tail}] <= task_reg;
        if (cmd.pop_read)
            rdata_reg <= mem[{cursor_reg, cur_head}];
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (mem_we)
            fill_next[enq_q] = enq_fill + FW'(1);
        if (cmd.pop_read)
        begin
            head_next[cursor_reg] = head_inc;
            fill_next[cursor_reg] = cur_fill - FW'(1);
        end
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        remain_next = remain_reg;
        scan_next   = scan_reg;
        slots_next  = slots_reg;
        if (cmd.load)
            slots_next = slots_sat;
        if (cmd.scan_clear)
            scan_next = '0;
        if (cmd.advance && (remain_reg == '0))
        begin
            cursor_next = cursor_adv;
            remain_next = RW'(1) << cursor_adv;
        end
        if (cmd.skip)
        begin
            remain_next = '0;
            scan_next   = scan_reg + QW'(1);
        end
        if (cmd.pop_take)
        begin
            remain_next = remain_reg - RW'(1);
            slots_next  = slots_reg - CW'(1);
            if (remain_reg == RW'(1))
                scan_next = scan_reg + QW'(1);
        end
    end

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (cmd.pop_take)
            held_valid_next = 1'b1;
        else if (cmd.flush_mid || cmd.finish)
            held_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_task_next  = out_task_reg;
        out_q_next     = out_q_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (cmd.enqueue)
            begin
                out_kind_next = enq_ok ? ffexrr_pkg::KIND_QUEUED : ffexrr_pkg::KIND_TO_GLOBAL;
                out_task_next = task_reg;
                out_q_next    = XW'(enq_q);
                out_last_next = 1'b1;
            end
            else if (cmd.pop_take || cmd.flush_mid)
            begin
                out_kind_next = ffexrr_pkg::KIND_DISPATCHED;
                out_task_next = held_task_reg;
                out_q_next    = XW'(held_q_reg);
                out_last_next = 1'b0;
            end
            else if (cmd.finish && held_valid_reg)
            begin
                out_kind_next = ffexrr_pkg::KIND_DISPATCHED;
                out_task_next = held_task_reg;
                out_q_next    = XW'(held_q_reg);
                out_last_next = 1'b1;
            end
            else
            begin
                out_kind_next = cmd.finish ? ffexrr_pkg::KIND_NOTHING
                                           : ffexrr_pkg::KIND_MOVE_GLOBAL;
                out_task_next = '0;
                out_q_next    = '0;
                out_last_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thermal_reg    <= ffexrr_pkg::THERM_COOL;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            cursor_reg     <= '0;
            remain_reg     <= '0;
            scan_reg       <= '0;
            slots_reg      <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                thermal_reg <= cfg_wdata;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            cursor_reg     <= cursor_next;
            remain_reg     <= remain_next;
            scan_reg       <= scan_next;
            slots_reg      <= slots_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= s_tuser;
            task_reg    <= s_tdata[ffexrr_pkg::TASK_LSB +: TW];
            weight_reg  <= s_tdata[ffexrr_pkg::WEIGHT_LSB +: ffexrr_pkg::WEIGHT_W];
            reenq_reg   <= s_tdata[ffexrr_pkg::REENQ_BIT];
            gpend_reg   <= s_tdata[ffexrr_pkg::GPEND_BIT];
        end
        if (cmd.pop_take)
        begin
            held_task_reg <= rdata_reg;
            held_q_reg    <= cursor_reg;
        end
        out_kind_reg <= out_kind_next;
        out_task_reg <= out_task_next;
        out_q_reg    <= out_q_next;
        out_last_reg <= out_last_next;
    end

    assign stat.command     = command_reg;
    assign stat.gpend       = gpend_reg;
    assign stat.slots_zero  = (slots_reg == '0);
    assign stat.slots_one   = (slots_reg == CW'(1));
    assign stat.queue_empty = (cur_fill == '0);
    assign stat.remain_one  = (remain_reg == RW'(1));
    assign stat.scan_last   = (scan_reg == QW'(NUM_QUEUES - 1));
    assign stat.held_valid  = held_valid_reg;
    assign stat.out_free    = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{ffexrr_pkg::M_PAD_W{1'b0}}, out_q_reg, out_task_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, cmd.pop_read, cur_fill != '0)
    `ASSERT_IMPLIES(a_push_room, clk, rst_n, mem_we, enq_fill < FW'(QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_load_free, clk, rst_n, out_load, out_free)
    `ASSERT_IMPLIES(a_take_remain, clk, rst_n, cmd.pop_take, remain_reg != '0 && slots_reg != '0)

endmodule

/* sv/ffexrr_ctrl.sv */
// Controller of the scheduler core: sequences enqueue and dispatch steps.
// Depends on ffexrr_pkg; drives datapath commands, reads datapath status.
`timescale 1ns / 1ps

module ffexrr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  ffexrr_pkg::ctrl_stat_t stat,
    output ffexrr_pkg::ctrl_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DECODE  = 4'd1;
    localparam logic [3:0] ST_ENQ     = 4'd2;
    localparam logic [3:0] ST_ADVANCE = 4'd3;
    localparam logic [3:0] ST_CHECK   = 4'd4;
    localparam logic [3:0] ST_POP     = 4'd5;
    localparam logic [3:0] ST_EXHAUST = 4'd6;
    localparam logic [3:0] ST_GLOBAL  = 4'd7;
    localparam logic [3:0] ST_FINISH  = 4'd8;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.scan_clear = 1'b1;
                if (!stat.command)
                    state_next = ST_ENQ;
                else if (stat.gpend)
                    state_next = ST_GLOBAL;
                else if (stat.slots_zero)
                    state_next = ST_FINISH;
                else
                    state_next = ST_ADVANCE;
            end
            ST_ENQ:
            begin
                if (stat.out_free)
                begin
                    cmd.enqueue = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_ADVANCE:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.queue_empty)
                begin
                    cmd.skip   = 1'b1;
                    state_next = stat.scan_last ? ST_FINISH : ST_ADVANCE;
                end
                else
                begin
                    cmd.pop_read = 1'b1;
                    state_next   = ST_POP;
                end
            end
            ST_POP:
            begin
                if (!stat.held_valid || stat.out_free)
                begin
                    cmd.pop_take = 1'b1;
                    if (stat.slots_one)
                        state_next = ST_EXHAUST;
                    else if (stat.remain_one)
                        state_next = stat.scan_last ? ST_FINISH : ST_ADVANCE;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_EXHAUST:
            begin
                if (stat.out_free)
                begin
                    cmd.flush_mid = 1'b1;
                    state_next    = ST_GLOBAL;
                end
            end
            ST_GLOBAL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_global = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* sv/five_fifo_exponential_round_robin.sv */
// Enqueue: item loaded, decoded, result loaded out; next item taken once it is loaded out.
// Dispatch: a decode step, then per queue visited a cursor step plus, per pop, a queue check
// and a store read, or just the queue check if the queue is empty; the closing result is loaded
// once the scan ends, after a flush step when the slots run out. Output stalls hold the loading steps.
// Reset (async, active low) clears queue pointers, cursor, thermal stage; store is not cleared.
`timescale 1ns / 1ps

module five_fifo_exponential_round_robin #(
    parameter int QUEUE_DEPTH = ffexrr_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_QUEUES  = ffexrr_pkg::NUM_QUEUES_DEF,
    parameter int MAX_SLOTS   = ffexrr_pkg::MAX_SLOTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [ffexrr_pkg::THERM_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // task_id[21:0], weight[35:22], reenqueue[36], global_pending[37], free_slots[43:38]
    input  logic [ffexrr_pkg::S_TDATA_W-1:0]   s_tdata,
    // command[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_task[21:0], queue_index[24:22]
    output logic [ffexrr_pkg::M_TDATA_W-1:0]   m_tdata,
    // kind[2:0]
    output logic [ffexrr_pkg::KIND_W-1:0]      m_tuser,
    output logic                               m_tlast
);

    ffexrr_pkg::ctrl_cmd_t  cmd;
    ffexrr_pkg::ctrl_stat_t stat;

    ffexrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffexrr_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_QUEUES  (NUM_QUEUES),
        .MAX_SLOTS   (MAX_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* test/testbench.sv */
// Self-checking testbench for five_fifo_exponential_round_robin.
// Drives enqueue and dispatch items over the stream ports and scores every result item
// against an in-bench scheduler predictor or typed expected results; depends on ffexrr_pkg and the RTL only.
`timescale 1ns / 1ps

module testbench;

    localparam int NQ     = ffexrr_pkg::NUM_QUEUES_DEF;
    localparam int QDEPTH = ffexrr_pkg::QUEUE_DEPTH_DEF;
    localparam int MAXS   = ffexrr_pkg::MAX_SLOTS_DEF;

    localparam int TASK_W    = ffexrr_pkg::TASK_W;
    localparam int WEIGHT_W  = ffexrr_pkg::WEIGHT_W;
    localparam int SLOTS_W   = ffexrr_pkg::SLOTS_W;
    localparam int KIND_W    = ffexrr_pkg::KIND_W;
    localparam int QIDX_W    = ffexrr_pkg::QIDX_W;
    localparam int THERM_W   = ffexrr_pkg::THERM_W;
    localparam int S_TDATA_W = ffexrr_pkg::S_TDATA_W;
    localparam int M_TDATA_W = ffexrr_pkg::M_TDATA_W;

    localparam logic CMD_ENQUEUE  = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    localparam logic [THERM_W-1:0] PHASE_THERMAL [4] = '{ffexrr_pkg::THERM_WARM,
                                                         ffexrr_pkg::THERM_HOT,
                                                         ffexrr_pkg::THERM_CRITICAL,
                                                         ffexrr_pkg::THERM_COOL};
    localparam int PHASE_SEND_IDLE [4]   = '{0, 54, 0, 32};
    localparam int PHASE_RECV_STALL [4]  = '{0, 0, 54, 32};
    localparam int PHASE_ITEMS           = 48;
    localparam int WEIGHT_NEAR [8]       = '{25, 26, 50, 51, 199, 200, 399, 400};

    typedef struct packed {
        logic                command;
        logic [TASK_W-1:0]   tid;
        logic [WEIGHT_W-1:0] weight;
        logic                reenq;
        logic                gpend;
        logic [SLOTS_W-1:0]  slots;
    } sched_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TASK_W-1:0] tid;
        logic [QIDX_W-1:0] qidx;
        logic              last;
    } sched_res_t;

    typedef struct packed {
        sched_req_t req;
        logic       typed;
        sched_res_t want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic [THERM_W-1:0]     cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;

    // scheduler shadow state
    logic [TASK_W-1:0]  ring_mem [NQ][QDEPTH];
    int                 ring_head [NQ];
    int                 ring_count [NQ];
    int                 serve_cursor;
    int                 serve_left;
    logic [THERM_W-1:0] thermal_setting;

    sched_res_t step_out [$];
    sched_res_t due_results [$];
    dir_row_t   dir_rows [$];
    sched_res_t blank_result = '0;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int err_count       = 0;
    int redirects_full  = 0;

    five_fifo_exponential_round_robin dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: timeout with %0d results still due", due_results.size());
        $display("testbench: done, errors");
        $finish;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("mismatch at result %0d, %s: got %0h, want %0h (t=%0t)",
                 results_checked, what, got, want, $realtime);
    endtask

    function automatic void note_result(input logic [KIND_W-1:0] kind,
                                        input logic [TASK_W-1:0] tid,
                                        input logic [QIDX_W-1:0] qidx);
        sched_res_t r;
        r.kind = kind;
        r.tid  = tid;
        r.qidx = qidx;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic int weight_to_queue(input logic [WEIGHT_W-1:0] w);
        int lvl;
        lvl = int'(w > ffexrr_pkg::WEIGHT_LVL0) + int'(w > ffexrr_pkg::WEIGHT_LVL1)
            + int'(w >= ffexrr_pkg::WEIGHT_LVL2) + int'(w >= ffexrr_pkg::WEIGHT_LVL3);
        case (thermal_setting)
            ffexrr_pkg::THERM_WARM:
            begin
                if (lvl > 0)
                    lvl = lvl - 1;
            end
            ffexrr_pkg::THERM_HOT:
            begin
                if (lvl > 2)
                    lvl = 2;
            end
            ffexrr_pkg::THERM_CRITICAL:
            begin
                if (lvl > 1)
                    lvl = 1;
            end
            default:
            begin
            end
        endcase
        if (lvl > NQ - 1)
            lvl = NQ - 1;
        return lvl;
    endfunction

    // compute the result items of one accepted item into step_out
    function automatic void schedule_request(input sched_req_t req);
        int  q;
        int  budget;
        int  scan;
        bit  out_of_slots;
        bit  leave;
        step_out.delete();
        if (req.command == CMD_ENQUEUE)
        begin
            q = weight_to_queue(req.weight);
            if (req.reenq || ring_count[q] >= QDEPTH)
            begin
                if (!req.reenq)
                    redirects_full++;
                note_result(ffexrr_pkg::KIND_TO_GLOBAL, req.tid, QIDX_W'(q));
            end
            else
            begin
                ring_mem[q][(ring_head[q] + ring_count[q]) % QDEPTH] = req.tid;
                ring_count[q]++;
                note_result(ffexrr_pkg::KIND_QUEUED, req.tid, QIDX_W'(q));
            end
        end
        else if (req.gpend)
            note_result(ffexrr_pkg::KIND_MOVE_GLOBAL, '0, '0);
        else
        begin
            budget = (req.slots > MAXS) ? MAXS : int'(req.slots);
            out_of_slots = 1'b0;
            if (budget > 0)
                for (scan = 0; scan < NQ && !out_of_slots; scan++)
                begin
                    if (serve_left == 0)
                    begin
                        serve_cursor = (serve_cursor + 1) % NQ;
                        serve_left = 1 << serve_cursor;
                    end
                    q = serve_cursor;
                    leave = 1'b0;
                    while (!leave)
                    begin
                        if (ring_count[q] == 0)
                        begin
                            serve_left = 0;
                            leave = 1'b1;
                        end
                        else
                        begin
                            note_result(ffexrr_pkg::KIND_DISPATCHED, ring_mem[q][ring_head[q]],
                                        QIDX_W'(q));
                            ring_head[q] = (ring_head[q] + 1) % QDEPTH;
                            ring_count[q]--;
                            if (serve_left != 0)
                                serve_left--;
                            budget--;
                            if (budget == 0)
                            begin
                                note_result(ffexrr_pkg::KIND_MOVE_GLOBAL, '0, '0);
                                out_of_slots = 1'b1;
                                leave = 1'b1;
                            end
                            else if (serve_left == 0)
                                leave = 1'b1;
                        end
                    end
                end
            if (step_out.size() == 0)
                note_result(ffexrr_pkg::KIND_NOTHING, '0, '0);
        end
        step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    function automatic sched_req_t draw_request();
        sched_req_t r;
        r.tid   = TASK_W'($urandom);
        r.reenq = ($urandom_range(11) == 0);
        r.gpend = ($urandom_range(9) == 0);
        case ($urandom_range(7))
            0: r.weight = WEIGHT_W'($urandom_range(25, 1));
            1: r.weight = WEIGHT_W'($urandom_range(50, 26));
            2: r.weight = WEIGHT_W'($urandom_range(199, 51));
            3: r.weight = WEIGHT_W'($urandom_range(399, 200));
            4: r.weight = WEIGHT_W'($urandom_range(10000, 400));
            5: r.weight = WEIGHT_W'(WEIGHT_NEAR[$urandom_range(7)]);
            6: r.weight = $urandom_range(1) ? '0 : WEIGHT_W'($urandom_range(16383, 10001));
            default: r.weight = WEIGHT_W'($urandom_range(16383));
        endcase
        case ($urandom_range(9))
            0: r.slots = '0;
            1: r.slots = SLOTS_W'($urandom_range(63, 32));
            2: r.slots = SLOTS_W'($urandom_range(31, 9));
            default: r.slots = SLOTS_W'($urandom_range(8, 1));
        endcase
        r.command = ($urandom_range(99) < 45) ? CMD_DISPATCH : CMD_ENQUEUE;
        return r;
    endfunction

    function automatic void add_row(input logic cmd, input logic [TASK_W-1:0] tid,
                                    input logic [WEIGHT_W-1:0] w, input logic re,
                                    input logic gp, input logic [SLOTS_W-1:0] sl,
                                    input logic typed, input logic [KIND_W-1:0] kind,
                                    input logic [TASK_W-1:0] otid,
                                    input logic [QIDX_W-1:0] q);
        dir_row_t row;
        row.req.command = cmd;
        row.req.tid     = tid;
        row.req.weight  = w;
        row.req.reenq   = re;
        row.req.gpend   = gp;
        row.req.slots   = sl;
        row.typed       = typed;
        row.want.kind   = kind;
        row.want.tid    = otid;
        row.want.qidx   = q;
        row.want.last   = 1'b1;
        dir_rows.push_back(row);
    endfunction

    task automatic send_request(input sched_req_t req, input logic typed,
                                input sched_res_t want);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.command;
        s_tdata  <= {4'b0, req.slots, req.gpend, req.reenq, req.weight, req.tid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        schedule_request(req);
        if (typed)
            due_results.push_back(want);
        else
            foreach (step_out[i])
                due_results.push_back(step_out[i]);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_thermal(input logic [THERM_W-1:0] stage);
        cfg_wen   <= 1'b1;
        cfg_wdata <= stage;
        @(posedge clk);
        cfg_wen <= 1'b0;
        thermal_setting = stage;
    endtask

    task automatic send_enqueue(input logic [WEIGHT_W-1:0] w);
        sched_req_t r;
        r = draw_request();
        r.command = CMD_ENQUEUE;
        r.reenq   = 1'b0;
        r.weight  = w;
        send_request(r, 1'b0, blank_result);
    endtask

    task automatic send_dispatch(input logic [SLOTS_W-1:0] sl);
        sched_req_t r;
        r = draw_request();
        r.command = CMD_DISPATCH;
        r.gpend   = 1'b0;
        r.slots   = sl;
        send_request(r, 1'b0, blank_result);
    endtask

    always @(posedge clk)
    begin
        sched_res_t want;
        if (m_tvalid && m_tready)
        begin
            results_checked++;
            if (due_results.size() == 0)
                flag_mismatch("item with nothing due", int'(m_tuser), 0);
            else
            begin
                want = due_results.pop_front();
                if (m_tuser != want.kind)
                    flag_mismatch("kind", int'(m_tuser), int'(want.kind));
                if (m_tdata[TASK_W-1:0] != want.tid)
                    flag_mismatch("out_task", int'(m_tdata[TASK_W-1:0]), int'(want.tid));
                if (m_tdata[TASK_W+QIDX_W-1:TASK_W] != want.qidx)
                    flag_mismatch("queue_index", int'(m_tdata[TASK_W+QIDX_W-1:TASK_W]),
                                  int'(want.qidx));
                if (m_tlast != want.last)
                    flag_mismatch("last", int'(m_tlast), int'(want.last));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        int ph;
        int n;
        for (n = 0; n < NQ; n++)
        begin
            ring_head[n]  = 0;
            ring_count[n] = 0;
        end
        serve_cursor    = 0;
        serve_left      = 0;
        thermal_setting = ffexrr_pkg::THERM_COOL;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_thermal(ffexrr_pkg::THERM_COOL);

        // empty queues, global pending, weight extremes and thresholds, redirect, slot limits
        add_row(CMD_DISPATCH, 22'h000123, 14'd7, 1'b0, 1'b0, 6'd5,
                1'b1, ffexrr_pkg::KIND_NOTHING, '0, '0);
        add_row(CMD_DISPATCH, 22'h3FFFFF, 14'h3FFF, 1'b1, 1'b1, 6'd63,
                1'b1, ffexrr_pkg::KIND_MOVE_GLOBAL, '0, '0);
        add_row(CMD_ENQUEUE, 22'h3FFFFF, 14'd0, 1'b0, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_QUEUED, 22'h3FFFFF, 3'd0);
        add_row(CMD_ENQUEUE, 22'h000000, 14'h3FFF, 1'b0, 1'b1, 6'd63,
                1'b1, ffexrr_pkg::KIND_QUEUED, 22'h000000, 3'd4);
        add_row(CMD_ENQUEUE, 22'h000011, 14'd25, 1'b0, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_QUEUED, 22'h000011, 3'd0);
        add_row(CMD_ENQUEUE, 22'h000012, 14'd26, 1'b0, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_QUEUED, 22'h000012, 3'd1);
        add_row(CMD_ENQUEUE, 22'h000013, 14'd50, 1'b0, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_QUEUED, 22'h000013, 3'd1);
        add_row(CMD_ENQUEUE, 22'h000014, 14'd51, 1'b0, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_QUEUED, 22'h000014, 3'd2);
        add_row(CMD_ENQUEUE, 22'h000015, 14'd199, 1'b0, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_QUEUED, 22'h000015, 3'd2);
        add_row(CMD_ENQUEUE, 22'h000016, 14'd200, 1'b0, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_QUEUED, 22'h000016, 3'd3);
        add_row(CMD_ENQUEUE, 22'h000017, 14'd399, 1'b0, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_QUEUED, 22'h000017, 3'd3);
        add_row(CMD_ENQUEUE, 22'h000018, 14'd400, 1'b0, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_QUEUED, 22'h000018, 3'd4);
        add_row(CMD_ENQUEUE, 22'h000019, 14'd10000, 1'b0, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_QUEUED, 22'h000019, 3'd4);
        add_row(CMD_ENQUEUE, 22'h00001A, 14'd1, 1'b0, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_QUEUED, 22'h00001A, 3'd0);
        add_row(CMD_ENQUEUE, 22'h2AAAAA, 14'd300, 1'b1, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_TO_GLOBAL, 22'h2AAAAA, 3'd3);
        add_row(CMD_DISPATCH, 22'h155555, 14'h1555, 1'b1, 1'b0, 6'd0,
                1'b1, ffexrr_pkg::KIND_NOTHING, '0, '0);
        add_row(CMD_DISPATCH, 22'h000000, 14'd0, 1'b0, 1'b0, 6'd1,
                1'b0, ffexrr_pkg::KIND_NOTHING, '0, '0);
        add_row(CMD_DISPATCH, 22'h000000, 14'd0, 1'b0, 1'b0, 6'd3,
                1'b0, ffexrr_pkg::KIND_NOTHING, '0, '0);
        add_row(CMD_DISPATCH, 22'h000000, 14'd0, 1'b0, 1'b0, 6'd63,
                1'b0, ffexrr_pkg::KIND_NOTHING, '0, '0);
        add_row(CMD_ENQUEUE, 22'h0ABCDE, 14'd120, 1'b0, 1'b1, 6'd63,
                1'b0, ffexrr_pkg::KIND_NOTHING, '0, '0);
        add_row(CMD_DISPATCH, 22'h000000, 14'd0, 1'b0, 1'b0, 6'd32,
                1'b0, ffexrr_pkg::KIND_NOTHING, '0, '0);
        add_row(CMD_DISPATCH, 22'h000000, 14'd0, 1'b0, 1'b0, 6'd32,
                1'b0, ffexrr_pkg::KIND_NOTHING, '0, '0);
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        for (ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            set_thermal(PHASE_THERMAL[ph]);
            sender_idle_pct = PHASE_SEND_IDLE[ph];
            recv_stall_pct  = PHASE_RECV_STALL[ph];
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold until the block has emptied out
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                send_request(draw_request(), 1'b0, blank_result);
            end
        end

        // load the top queue, then drain it with full and random slot counts
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        for (n = 0; n < 8; n++)
            send_enqueue(WEIGHT_W'($urandom_range(10000, 400)));
        for (n = 0; n < 3; n++)
            send_dispatch(6'd32);
        recv_stall_pct = 32;
        for (n = 0; n < 6; n++)
            send_dispatch(SLOTS_W'($urandom_range(63, 1)));

        wait_drained();
        repeat (20) @(posedge clk);
        $display("testbench: %0d items sent, %0d result items scored, all thermal stages",
                 items_sent, results_checked);
        $display("testbench: idle/stall mixes, drain pauses, %0d full-queue redirects",
                 redirects_full);
        if (err_count == 0 && due_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
